// ===== src/epfm_pkg.sv =====
package epfm_pkg;

  localparam int LEN_W   = 7;
  localparam int PIDX_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int MIDX_W  = 32;

  // request kinds carried in tuser
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [PIDX_W-1:0] pattern_index;
    logic [BYTE_W-1:0] data_byte;
    logic              last_item;
  } epfm_item_t;

  typedef struct packed {
    logic              found;
    logic [MIDX_W-1:0] match_index;
  } epfm_result_t;

endpackage

// ===== src/epfm_store.sv =====
module epfm_store #(
  parameter int MAX_PATTERN_LEN = 64
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [epfm_pkg::PIDX_W-1:0]         wr_idx,
  input  logic [epfm_pkg::BYTE_W-1:0]         wr_data,
  input  logic [epfm_pkg::BYTE_W-1:0]         cmp_byte,
  output logic [MAX_PATTERN_LEN-1:0]          eq
);
  import epfm_pkg::*;

  logic [BYTE_W-1:0] store_r [MAX_PATTERN_LEN];

  // one register per pattern position, each compared against the text byte
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      if (wr_en && (wr_idx == PIDX_W'(i))) begin
        store_r[i] <= wr_data;
      end
    end
  end

  for (genvar g = 0; g < MAX_PATTERN_LEN; g++) begin : g_entry
    assign eq[g] = (store_r[g] == cmp_byte);
  end

endmodule

// ===== src/epfm_match.sv =====
module epfm_match #(
  parameter int MAX_PATTERN_LEN = 64,
  parameter int TEXT_INDEX_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         text_en,
  input  logic                         last_item,
  input  logic [MAX_PATTERN_LEN-1:0]   eq,
  input  logic [epfm_pkg::LEN_W-1:0]   pattern_len,
  output logic                         res_valid,
  output epfm_pkg::epfm_result_t       res
);
  import epfm_pkg::*;

  localparam int SUB_W = (TEXT_INDEX_BITS > MIDX_W) ? TEXT_INDEX_BITS : MIDX_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_LEN);

  logic [MAX_PATTERN_LEN-1:0] pm_r, pm_nxt;
  logic [TEXT_INDEX_BITS-1:0] pos_r, pos_nxt;
  logic                       reported_r, reported_nxt;

  logic [LEN_W-1:0]           len_eff, len_m1;
  logic [MAX_PATTERN_LEN-1:0] len_mask, top_sel, pm_upd;
  logic [MAX_PATTERN_LEN:0]   pm_shift;
  logic                       hit, pos_sat;
  logic [SUB_W-1:0]           start_idx;

  always_comb begin
    priority if (pattern_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_len > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = pattern_len;
    end
    len_m1 = len_eff - LEN_W'(1);
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      len_mask[i] = (LEN_W'(i) < len_eff);
      top_sel[i]  = (LEN_W'(i) == len_m1);
    end
  end

  assign pm_shift  = {pm_r, 1'b1};
  assign pm_upd    = pm_shift[MAX_PATTERN_LEN-1:0] & eq & len_mask;
  assign pos_sat   = &pos_r;
  assign hit       = |(pm_upd & top_sel);
  assign start_idx = SUB_W'(pos_r) - SUB_W'(len_m1);

  always_comb begin
    pm_nxt          = pm_r;
    pos_nxt         = pos_r;
    reported_nxt    = reported_r;
    res_valid       = 1'b0;
    res.found       = 1'b0;
    res.match_index = '0;
    if (text_en) begin
      if (!reported_r) begin
        pm_nxt = pm_upd;
        if (hit && !pos_sat) begin
          reported_nxt    = 1'b1;
          res_valid       = 1'b1;
          res.found       = 1'b1;
          res.match_index = start_idx[MIDX_W-1:0];
        end else if (last_item) begin
          res_valid = 1'b1;
        end
      end
      if (!pos_sat) begin
        pos_nxt = pos_r + TEXT_INDEX_BITS'(1);
      end
      // the last byte always ends the search
      if (last_item) begin
        pm_nxt       = '0;
        pos_nxt      = '0;
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r       <= '0;
      pos_r      <= '0;
      reported_r <= 1'b0;
    end else begin
      pm_r       <= pm_nxt;
      pos_r      <= pos_nxt;
      reported_r <= reported_nxt;
    end
  end

endmodule

// ===== src/exact_pattern_first_match.sv =====
// result path: an accepted item goes through the input register, then its result
// through the result register, to out_tdata/out_tuser
// throughput: one item per cycle while out_tready is high; a result waiting on
// out_tready holds the next item in the input register
// reset (rst_n, synchronous): clears search state and pattern length to 1;
// the pattern store is not cleared and must be written before use
module exact_pattern_first_match #(
  parameter int MAX_PATTERN_LEN = 64,
  parameter int TEXT_INDEX_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [epfm_pkg::LEN_W-1:0]  cfg_data,     // pattern_len
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,     // pattern_index[5:0], data_byte[13:6]
  input  logic                        in_tuser,     // req_type
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,    // match_index[31:0]
  output logic                        out_tuser     // found
);
  import epfm_pkg::*;

  logic [LEN_W-1:0]           pattern_len_r;
  logic                       s_valid_r;
  epfm_item_t                 s_item_r;
  logic                       out_valid_r;
  epfm_result_t               out_res_r;
  logic                       adv, text_en, res_valid;
  logic [MAX_PATTERN_LEN-1:0] eq;
  epfm_result_t               res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r <= LEN_W'(1);
    end else if (cfg_valid) begin
      pattern_len_r <= cfg_data;
    end
  end

  assign adv       = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || adv;
  assign text_en   = adv && (s_item_r.req_type == REQ_TEXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_item_r.req_type      <= in_tuser;
      s_item_r.pattern_index <= in_tdata[PIDX_W-1:0];
      s_item_r.data_byte     <= in_tdata[PIDX_W+BYTE_W-1:PIDX_W];
      s_item_r.last_item     <= in_tlast;
    end
  end

  epfm_store #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_store (
    .clk      (clk),
    .wr_en    (adv && (s_item_r.req_type == REQ_PATTERN)),
    .wr_idx   (s_item_r.pattern_index),
    .wr_data  (s_item_r.data_byte),
    .cmp_byte (s_item_r.data_byte),
    .eq       (eq)
  );

  epfm_match #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
    .TEXT_INDEX_BITS(TEXT_INDEX_BITS)
  ) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_en     (text_en),
    .last_item   (s_item_r.last_item),
    .eq          (eq),
    .pattern_len (pattern_len_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.match_index;
  assign out_tuser  = out_res_r.found;

endmodule
